@@ rtl/cdt_pkg.sv @@
package cdt_pkg;

   localparam int unsigned SWITCH_W = 10;
   localparam int unsigned HUND_W = 7;
   localparam int unsigned SEC_W = 6;
   localparam int unsigned MIN_W = 6;
   localparam int unsigned SEG_W = 8;
   localparam int unsigned LED_W = 4;

   localparam logic [HUND_W-1:0] HUND_MAX = 7'd99;
   localparam logic [SEC_W-1:0] SEC_MAX = 6'd59;
   localparam logic [MIN_W-1:0] MIN_MAX = 6'd59;

   localparam logic [LED_W-1:0] LED_NONE = 4'd0;
   localparam logic [LED_W-1:0] LED_RUN = 4'd1;
   localparam logic [LED_W-1:0] LED_HUND = 4'd2;
   localparam logic [LED_W-1:0] LED_SEC = 4'd4;
   localparam logic [LED_W-1:0] LED_MIN = 4'd8;

   localparam logic [SEG_W-1:0] SEG_CODE [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   typedef struct packed {
      logic start_level;
      logic set_hund_level;
      logic set_sec_level;
      logic set_min_level;
      logic [SWITCH_W-1:0] switch_value;
      logic tick;
   } req_word_type;

   typedef struct packed {
      logic [4*SEG_W-1:0] digits_low;
      logic [2*SEG_W-1:0] digits_high;
      logic [LED_W-1:0] leds;
      logic running;
   } rsp_word_type;

   typedef struct packed {
      logic run_flag;
      logic prev_start;
      logic [HUND_W-1:0] hundredths;
      logic [SEC_W-1:0] seconds;
      logic [MIN_W-1:0] minutes;
   } state_type;

   // two seven-segment codes for a value of 0..99, tens via multiply by 103/1024
   function automatic logic [2*SEG_W-1:0] pair_code(input logic [HUND_W-1:0] v);
      logic [13:0] prod;
      logic [3:0] tens;
      logic [HUND_W-1:0] tens_x10;
      logic [3:0] ones;
      prod = 14'(v) * 14'd103;
      tens = prod[13:10];
      tens_x10 = 7'(tens) * 7'd10;
      ones = 4'(v - tens_x10);
      return {SEG_CODE[tens], SEG_CODE[ones]};
   endfunction

endpackage

@@ rtl/cdt_if.sv @@
interface cdt_req_if;
   logic valid;
   logic ready;
   logic start_level;
   logic set_hund_level;
   logic set_sec_level;
   logic set_min_level;
   logic [cdt_pkg::SWITCH_W-1:0] switch_value;
   logic tick;

   modport source (
      output valid, start_level, set_hund_level, set_sec_level, set_min_level,
         switch_value, tick,
      input ready
   );
   modport sink (
      input valid, start_level, set_hund_level, set_sec_level, set_min_level,
         switch_value, tick,
      output ready
   );
endinterface

interface cdt_rsp_if;
   logic valid;
   logic ready;
   logic [4*cdt_pkg::SEG_W-1:0] digits_low;
   logic [2*cdt_pkg::SEG_W-1:0] digits_high;
   logic [cdt_pkg::LED_W-1:0] leds;
   logic running;

   modport source (
      output valid, digits_low, digits_high, leds, running,
      input ready
   );
   modport sink (
      input valid, digits_low, digits_high, leds, running,
      output ready
   );
endinterface

@@ rtl/countdown_timer_seven_segment.sv @@
// an accepted request word passes through the input register, then through the step
// logic into the response register, before it is presented as its response word
// throughput: one word per cycle, with stalls only on response backpressure
// reset (synchronous, active high): paused, start released, time 00:00.00,
// both pipeline registers empty
module countdown_timer_seven_segment (
   input logic clock,
   input logic reset,
   cdt_req_if.sink req_bus,
   cdt_rsp_if.source rsp_bus
);

   logic in_valid_ff;
   logic in_valid_in;
   cdt_pkg::req_word_type in_word_ff;
   cdt_pkg::req_word_type in_word_in;
   logic out_valid_ff;
   logic out_valid_in;
   cdt_pkg::rsp_word_type out_word_ff;
   cdt_pkg::rsp_word_type out_word_in;
   cdt_pkg::state_type state_ff;
   cdt_pkg::state_type state_in;

   cdt_pkg::state_type step_state;
   logic [cdt_pkg::LED_W-1:0] step_leds;
   logic [4*cdt_pkg::SEG_W-1:0] disp_low;
   logic [2*cdt_pkg::SEG_W-1:0] disp_high;
   logic advance;
   logic take;

   cdt_step u_step (
      .cur(state_ff),
      .word(in_word_ff),
      .nxt(step_state),
      .leds(step_leds)
   );

   cdt_display u_display (
      .cur(step_state),
      .digits_low(disp_low),
      .digits_high(disp_high)
   );

   always_comb begin
      advance = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
      take = req_bus.valid && req_bus.ready;

      in_valid_in = take || (in_valid_ff && !advance);
      in_word_in = in_word_ff;
      if (take) begin
         in_word_in = '{
            start_level: req_bus.start_level,
            set_hund_level: req_bus.set_hund_level,
            set_sec_level: req_bus.set_sec_level,
            set_min_level: req_bus.set_min_level,
            switch_value: req_bus.switch_value,
            tick: req_bus.tick
         };
      end

      out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);
      out_word_in = out_word_ff;
      state_in = state_ff;
      if (advance) begin
         state_in = step_state;
         out_word_in = '{
            digits_low: disp_low,
            digits_high: disp_high,
            leds: step_leds,
            running: step_state.run_flag
         };
      end
   end

   assign req_bus.ready = !in_valid_ff || advance;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.digits_low = out_word_ff.digits_low;
   assign rsp_bus.digits_high = out_word_ff.digits_high;
   assign rsp_bus.leds = out_word_ff.leds;
   assign rsp_bus.running = out_word_ff.running;

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      out_word_ff <= out_word_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '{
            run_flag: 1'b0,
            prev_start: 1'b1,
            hundredths: '0,
            seconds: '0,
            minutes: '0
         };
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/cdt_step.sv @@
module cdt_step (
   input cdt_pkg::state_type cur,
   input cdt_pkg::req_word_type word,
   output cdt_pkg::state_type nxt,
   output logic [cdt_pkg::LED_W-1:0] leds
);

   always_comb begin
      nxt = cur;
      leds = cdt_pkg::LED_NONE;

      // falling edge on start toggles run
      if (!word.start_level && cur.prev_start) begin
         nxt.run_flag = !cur.run_flag;
         leds = nxt.run_flag ? cdt_pkg::LED_RUN : cdt_pkg::LED_NONE;
      end
      nxt.prev_start = word.start_level;

      // countdown with borrow, holds at zero
      if (nxt.run_flag && word.tick) begin
         if (cur.hundredths != '0) begin
            nxt.hundredths = cur.hundredths - cdt_pkg::HUND_W'(1);
         end else if (cur.seconds != '0) begin
            nxt.hundredths = cdt_pkg::HUND_MAX;
            nxt.seconds = cur.seconds - cdt_pkg::SEC_W'(1);
         end else if (cur.minutes != '0) begin
            nxt.hundredths = cdt_pkg::HUND_MAX;
            nxt.seconds = cdt_pkg::SEC_MAX;
            nxt.minutes = cur.minutes - cdt_pkg::MIN_W'(1);
         end
      end

      // saturating loads
      if (!word.set_hund_level) begin
         nxt.hundredths = (word.switch_value > cdt_pkg::SWITCH_W'(cdt_pkg::HUND_MAX)) ?
            cdt_pkg::HUND_MAX : word.switch_value[cdt_pkg::HUND_W-1:0];
         leds = cdt_pkg::LED_HUND;
      end
      if (!word.set_sec_level) begin
         nxt.seconds = (word.switch_value > cdt_pkg::SWITCH_W'(cdt_pkg::SEC_MAX)) ?
            cdt_pkg::SEC_MAX : word.switch_value[cdt_pkg::SEC_W-1:0];
         leds = cdt_pkg::LED_SEC;
      end
      if (!word.set_min_level) begin
         nxt.minutes = (word.switch_value > cdt_pkg::SWITCH_W'(cdt_pkg::MIN_MAX)) ?
            cdt_pkg::MIN_MAX : word.switch_value[cdt_pkg::MIN_W-1:0];
         leds = cdt_pkg::LED_MIN;
      end
   end

endmodule

@@ rtl/cdt_display.sv @@
module cdt_display (
   input cdt_pkg::state_type cur,
   output logic [4*cdt_pkg::SEG_W-1:0] digits_low,
   output logic [2*cdt_pkg::SEG_W-1:0] digits_high
);

   always_comb begin
      digits_low = {cdt_pkg::pair_code(cdt_pkg::HUND_W'(cur.seconds)),
                    cdt_pkg::pair_code(cur.hundredths)};
      digits_high = cdt_pkg::pair_code(cdt_pkg::HUND_W'(cur.minutes));
   end

endmodule
